// File: hdl/cascaded_position_velocity_pid_core_macros.svh
// Assertion macros used by the checker of the PID core.
`ifndef CASCADED_POSITION_VELOCITY_PID_CORE_MACROS_SVH
`define CASCADED_POSITION_VELOCITY_PID_CORE_MACROS_SVH

// Check a property at each rising clock edge, disabled while reset is high.
`define CPVP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define CPVP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/cpvp_pkg.sv
// Package with widths, constants and shared types of the cascaded PID core.
`timescale 1ns / 1ps

package cpvp_pkg;

   // Default loop geometry
   localparam int TURN_UNITS_DEF     = 360;
   localparam int WRAP_THRESHOLD_DEF = 180;

   // Field widths
   localparam int ANGLE_W    = 9;
   localparam int SPEED_W    = 16;
   localparam int POS_W      = 32;
   localparam int GAIN_W     = 24;
   localparam int LIMIT_W    = 15;
   localparam int DRIVE_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 16;

   // Datapath widths
   localparam int Q_FRAC  = 12;
   localparam int OPER_W  = 34;
   localparam int CHUNK_W = OPER_W / 2;
   localparam int MULP_W  = CHUNK_W + GAIN_W;
   localparam int PROD_W  = OPER_W + GAIN_W;
   localparam int ACC_W   = PROD_W - Q_FRAC + 2;
   localparam int EV_W    = SPEED_W + 1;
   localparam int DEV_W   = EV_W + 1;

   // Saturation bounds of the position error sum
   localparam logic signed [POS_W-1:0] POS_SUM_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_SUM_MIN = {1'b1, {(POS_W-1){1'b0}}};

   // Register reset values
   localparam logic [GAIN_W-1:0]  POS_GAIN_P_RST   = 24'd409600;
   localparam logic [GAIN_W-1:0]  POS_GAIN_I_RST   = 24'd0;
   localparam logic [GAIN_W-1:0]  POS_GAIN_D_RST   = 24'd40960;
   localparam logic [GAIN_W-1:0]  VEL_GAIN_P_RST   = 24'd4096;
   localparam logic [GAIN_W-1:0]  VEL_GAIN_I_RST   = 24'd0;
   localparam logic [GAIN_W-1:0]  VEL_GAIN_D_RST   = 24'd0;
   localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST  = 15'd30000;
   localparam logic [LIMIT_W-1:0] VEL_INT_LIMIT_RST = 15'd10000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POS_GAIN_P    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_GAIN_I    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_GAIN_D    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_GAIN_P    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_GAIN_I    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_GAIN_D    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_INT_LIMIT = 3'd7;

   // Operations of the shared multiply-accumulate unit
   typedef enum logic [2:0] {
      MAC_IDLE = 3'd0,
      MAC_LOAD = 3'd1,
      MAC_LO   = 3'd2,
      MAC_HI   = 3'd3,
      MAC_ACC  = 3'd4
   } mac_op_type;

   typedef struct packed {
      logic       clear;
      mac_op_type op;
   } mac_ctl_type;

   // Controls of the angle unwrapper
   typedef struct packed {
      logic turn_step;
      logic advance;
   } unw_ctl_type;

endpackage

// File: hdl/cpvp_unwrap.sv
// Angle unwrapper: holds the delayed raw angles and the turn counter.
`timescale 1ns / 1ps

module cpvp_unwrap #(
   parameter int WRAP_THRESHOLD = cpvp_pkg::WRAP_THRESHOLD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cpvp_pkg::unw_ctl_type         ctl,
   input  logic [cpvp_pkg::ANGLE_W-1:0]  angle_in,
   output logic [cpvp_pkg::ANGLE_W-1:0]  pending_angle,
   output logic [cpvp_pkg::POS_W-1:0]    turn_count
);

   logic [cpvp_pkg::ANGLE_W-1:0]        pending_ff, pending_in;
   logic [cpvp_pkg::ANGLE_W-1:0]        previous_ff, previous_in;
   logic [cpvp_pkg::POS_W-1:0]          turn_ff, turn_in;
   logic signed [cpvp_pkg::ANGLE_W:0]   delta;
   logic [cpvp_pkg::ANGLE_W:0]          delta_mag;
   logic                                wrapped;

   // Detect a jump of more than the wrap threshold between the last two angles
   always_comb begin
      delta     = $signed({1'b0, pending_ff}) - $signed({1'b0, previous_ff});
      delta_mag = (delta < 0) ? $unsigned(-delta) : $unsigned(delta);
      wrapped   = 32'(delta_mag) > 32'(WRAP_THRESHOLD);
   end

   // Step the turn count, then advance the angle history at the end of a tick
   always_comb begin
      pending_in  = pending_ff;
      previous_in = previous_ff;
      turn_in     = turn_ff;
      if (ctl.turn_step && wrapped) begin
         if (delta > 0) begin
            turn_in = turn_ff - 1'b1;
         end else begin
            turn_in = turn_ff + 1'b1;
         end
      end
      if (ctl.advance) begin
         previous_in = pending_ff;
         pending_in  = angle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         previous_ff <= '0;
         turn_ff     <= '0;
      end else begin
         pending_ff  <= pending_in;
         previous_ff <= previous_in;
         turn_ff     <= turn_in;
      end
   end

   assign pending_angle = pending_ff;
   assign turn_count    = turn_ff;

endmodule

// File: hdl/cpvp_mac.sv
// Shared multiply-accumulate unit: Q12.12 gain times signed operand, two passes.
`timescale 1ns / 1ps

module cpvp_mac (
   input  logic                                clock,
   input  cpvp_pkg::mac_ctl_type               ctl,
   input  logic [cpvp_pkg::GAIN_W-1:0]         gain,
   input  logic signed [cpvp_pkg::OPER_W-1:0]  operand,
   output logic signed [cpvp_pkg::ACC_W-1:0]   acc
);

   logic [cpvp_pkg::GAIN_W-1:0]        gain_ff, gain_in;
   logic [cpvp_pkg::OPER_W-1:0]        mag_ff, mag_in;
   logic                               neg_ff, neg_in;
   logic [cpvp_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic signed [cpvp_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [cpvp_pkg::CHUNK_W-1:0]       mul_a;
   logic [cpvp_pkg::MULP_W-1:0]        mul_p;
   logic signed [cpvp_pkg::ACC_W-1:0]  term;

   // One 24 x 17 multiplier, fed the low or high half of the magnitude
   always_comb begin
      mul_a = (ctl.op == cpvp_pkg::MAC_HI) ? mag_ff[cpvp_pkg::OPER_W-1:cpvp_pkg::CHUNK_W]
                                           : mag_ff[cpvp_pkg::CHUNK_W-1:0];
      mul_p = cpvp_pkg::MULP_W'(mul_a) * cpvp_pkg::MULP_W'(gain_ff);
      term  = $signed(cpvp_pkg::ACC_W'(prod_ff[cpvp_pkg::PROD_W-1:cpvp_pkg::Q_FRAC]));
   end

   // Load sign and magnitude, build the product, add the truncated term
   always_comb begin
      gain_in = gain_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      unique case (ctl.op)
         cpvp_pkg::MAC_IDLE: begin
         end
         cpvp_pkg::MAC_LOAD: begin
            gain_in = gain;
            neg_in  = operand[cpvp_pkg::OPER_W-1];
            mag_in  = operand[cpvp_pkg::OPER_W-1] ? $unsigned(-operand) : $unsigned(operand);
         end
         cpvp_pkg::MAC_LO: begin
            prod_in = cpvp_pkg::PROD_W'(mul_p);
         end
         cpvp_pkg::MAC_HI: begin
            prod_in = prod_ff + {mul_p, {cpvp_pkg::CHUNK_W{1'b0}}};
         end
         cpvp_pkg::MAC_ACC: begin
            acc_in = neg_ff ? (acc_ff - term) : (acc_ff + term);
         end
         default: begin
         end
      endcase
      if (ctl.clear) begin
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      gain_ff <= gain_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// File: hdl/cascaded_position_velocity_pid_core.sv
// Top level of the cascaded position and velocity PID core with its sequencer.
`timescale 1ns / 1ps

// One control tick per accepted item: the raw angle delivered on the previous
// tick is unwrapped into an absolute position, an outer position PID yields a
// speed target and an inner velocity PID yields the drive value, saturated to
// +-drive_limit. A new item is taken only in the idle state, so no item is
// accepted while one is in progress; each tick runs on the single shared
// 24 x 17 bit multiplier, which spends two passes plus a load and an accumulate
// step on each of the six gain products, besides the position, sum and clamp
// steps. The result sits in an output register and may wait there while the
// next item is taken in. hold_output only clears drive_send; all loop state
// advances as usual. Registers are to be written only while the core is idle; the core does not enforce this.

module cascaded_position_velocity_pid_core #(
   parameter int TURN_UNITS     = cpvp_pkg::TURN_UNITS_DEF,
   parameter int WRAP_THRESHOLD = cpvp_pkg::WRAP_THRESHOLD_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // raw_angle[8:0], measured_speed[24:9], target_position[56:25],
   // zero_offset[88:57], zero[95:89]
   input  logic [cpvp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // hold_output
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // drive_value[15:0]
   output logic [cpvp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // drive_send
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wen,
   input  logic [cpvp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cpvp_pkg::GAIN_W-1:0]         csr_wdata
);

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_TURN = 13'b0000000000010,
      ST_POSN = 13'b0000000000100,
      ST_ERR  = 13'b0000000001000,
      ST_PSUM = 13'b0000000010000,
      ST_LOAD = 13'b0000000100000,
      ST_MLO  = 13'b0000001000000,
      ST_MHI  = 13'b0000010000000,
      ST_ACC  = 13'b0000100000000,
      ST_UCLP = 13'b0001000000000,
      ST_VSUM = 13'b0010000000000,
      ST_VCLP = 13'b0100000000000,
      ST_RSVD = 13'b1000000000000
   } state_type;

   // Gain product order
   localparam logic [2:0] TERM_POS_P = 3'd0;
   localparam logic [2:0] TERM_POS_I = 3'd1;
   localparam logic [2:0] TERM_POS_D = 3'd2;
   localparam logic [2:0] TERM_VEL_P = 3'd3;
   localparam logic [2:0] TERM_VEL_I = 3'd4;
   localparam logic [2:0] TERM_VEL_D = 3'd5;

   localparam int AW = cpvp_pkg::ACC_W;
   localparam int PW = cpvp_pkg::POS_W;

   // Configuration registers
   logic [cpvp_pkg::GAIN_W-1:0]   pos_gp_ff, pos_gp_in, pos_gi_ff, pos_gi_in;
   logic [cpvp_pkg::GAIN_W-1:0]   pos_gd_ff, pos_gd_in, vel_gp_ff, vel_gp_in;
   logic [cpvp_pkg::GAIN_W-1:0]   vel_gi_ff, vel_gi_in, vel_gd_ff, vel_gd_in;
   logic [cpvp_pkg::LIMIT_W-1:0]  drive_lim_ff, drive_lim_in;
   logic [cpvp_pkg::LIMIT_W-1:0]  vint_lim_ff, vint_lim_in;

   // Latched item
   logic [cpvp_pkg::ANGLE_W-1:0]        angle_ff, angle_in;
   logic signed [cpvp_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic [PW-1:0]                       target_ff, target_in;
   logic [PW-1:0]                       offset_ff, offset_in;
   logic                                hold_ff, hold_in;

   // Loop state and intermediates
   logic [PW-1:0]                       tprod_ff, tprod_in;
   logic signed [PW-1:0]                e_ff, e_in;
   logic signed [PW-1:0]                pos_sum_ff, pos_sum_in;
   logic signed [PW-1:0]                last_e_ff, last_e_in;
   logic signed [cpvp_pkg::EV_W-1:0]    ev_ff, ev_in;
   logic signed [cpvp_pkg::EV_W-1:0]    last_ev_ff, last_ev_in;
   logic signed [cpvp_pkg::SPEED_W-1:0] spd_sum_ff, spd_sum_in;

   // Output register and sequencer
   logic signed [cpvp_pkg::DRIVE_W-1:0] drive_ff, drive_in;
   logic                                send_ff, send_in;
   logic                                out_valid_ff, out_valid_in;
   logic [2:0]                          term_ff, term_in;
   state_type                           state_ff, state_in;

   logic [cpvp_pkg::ANGLE_W-1:0]        pending_angle;
   logic [PW-1:0]                       turn_count;
   logic signed [AW-1:0]                acc;
   logic signed [cpvp_pkg::OPER_W-1:0]  operand;
   logic [cpvp_pkg::GAIN_W-1:0]         gain;
   logic signed [PW:0]                  diff_e;
   logic signed [cpvp_pkg::DEV_W-1:0]   diff_ev;
   logic signed [PW:0]                  psum_wide;
   logic signed [cpvp_pkg::DEV_W-1:0]   vsum_wide;
   logic signed [cpvp_pkg::DRIVE_W-1:0] u_clamped;
   logic                                out_free;
   cpvp_pkg::mac_ctl_type               mac_ctl;
   cpvp_pkg::unw_ctl_type               unw_ctl;

   // Symmetric clamp of a wide signed value to +-lim
   function automatic logic signed [cpvp_pkg::DRIVE_W-1:0] clamp_sym(
      input logic signed [AW-1:0]          v,
      input logic [cpvp_pkg::LIMIT_W-1:0]  lim
   );
      logic signed [AW-1:0]                hi;
      logic signed [AW-1:0]                lo;
      logic signed [cpvp_pkg::DRIVE_W-1:0] r;
      hi = $signed(AW'(lim));
      lo = -hi;
      if (v > hi) begin
         r = cpvp_pkg::DRIVE_W'(hi);
      end else if (v < lo) begin
         r = cpvp_pkg::DRIVE_W'(lo);
      end else begin
         r = cpvp_pkg::DRIVE_W'(v);
      end
      return r;
   endfunction

   cpvp_unwrap #(
      .WRAP_THRESHOLD (WRAP_THRESHOLD)
   ) u_unwrap (
      .clock         (clock),
      .reset         (reset),
      .ctl           (unw_ctl),
      .angle_in      (angle_ff),
      .pending_angle (pending_angle),
      .turn_count    (turn_count)
   );

   cpvp_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .gain    (gain),
      .operand (operand),
      .acc     (acc)
   );

   // Select the gain and the error operand of the current product
   always_comb begin
      diff_e  = (PW + 1)'(e_ff) - (PW + 1)'(last_e_ff);
      diff_ev = cpvp_pkg::DEV_W'(ev_ff) - cpvp_pkg::DEV_W'(last_ev_ff);
      unique case (term_ff)
         TERM_POS_P: begin
            gain    = pos_gp_ff;
            operand = cpvp_pkg::OPER_W'(e_ff);
         end
         TERM_POS_I: begin
            gain    = pos_gi_ff;
            operand = cpvp_pkg::OPER_W'(pos_sum_ff);
         end
         TERM_POS_D: begin
            gain    = pos_gd_ff;
            operand = cpvp_pkg::OPER_W'(diff_e);
         end
         TERM_VEL_P: begin
            gain    = vel_gp_ff;
            operand = cpvp_pkg::OPER_W'(ev_ff);
         end
         TERM_VEL_I: begin
            gain    = vel_gi_ff;
            operand = cpvp_pkg::OPER_W'(spd_sum_ff);
         end
         TERM_VEL_D: begin
            gain    = vel_gd_ff;
            operand = cpvp_pkg::OPER_W'(diff_ev);
         end
         default: begin
            gain    = '0;
            operand = '0;
         end
      endcase
   end

   // Take configuration writes; unknown indexes cannot occur at this width
   always_comb begin
      pos_gp_in    = pos_gp_ff;
      pos_gi_in    = pos_gi_ff;
      pos_gd_in    = pos_gd_ff;
      vel_gp_in    = vel_gp_ff;
      vel_gi_in    = vel_gi_ff;
      vel_gd_in    = vel_gd_ff;
      drive_lim_in = drive_lim_ff;
      vint_lim_in  = vint_lim_ff;
      if (csr_wen) begin
         unique case (csr_index)
            cpvp_pkg::CSR_POS_GAIN_P:    pos_gp_in    = csr_wdata;
            cpvp_pkg::CSR_POS_GAIN_I:    pos_gi_in    = csr_wdata;
            cpvp_pkg::CSR_POS_GAIN_D:    pos_gd_in    = csr_wdata;
            cpvp_pkg::CSR_VEL_GAIN_P:    vel_gp_in    = csr_wdata;
            cpvp_pkg::CSR_VEL_GAIN_I:    vel_gi_in    = csr_wdata;
            cpvp_pkg::CSR_VEL_GAIN_D:    vel_gd_in    = csr_wdata;
            cpvp_pkg::CSR_DRIVE_LIMIT:   drive_lim_in = csr_wdata[cpvp_pkg::LIMIT_W-1:0];
            cpvp_pkg::CSR_VEL_INT_LIMIT: vint_lim_in  = csr_wdata[cpvp_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !out_valid_ff || rsp_tready;

   // Sequencer: position error, outer PID, speed error, inner PID, result
   always_comb begin
      angle_in     = angle_ff;
      speed_in     = speed_ff;
      target_in    = target_ff;
      offset_in    = offset_ff;
      hold_in      = hold_ff;
      tprod_in     = tprod_ff;
      e_in         = e_ff;
      pos_sum_in   = pos_sum_ff;
      last_e_in    = last_e_ff;
      ev_in        = ev_ff;
      last_ev_in   = last_ev_ff;
      spd_sum_in   = spd_sum_ff;
      drive_in     = drive_ff;
      send_in      = send_ff;
      out_valid_in = out_valid_ff;
      term_in      = term_ff;
      state_in     = state_ff;
      mac_ctl      = '{clear: 1'b0, op: cpvp_pkg::MAC_IDLE};
      unw_ctl      = '{turn_step: 1'b0, advance: 1'b0};
      psum_wide    = (PW + 1)'(pos_sum_ff) + (PW + 1)'(e_ff);
      vsum_wide    = cpvp_pkg::DEV_W'(spd_sum_ff) + cpvp_pkg::DEV_W'(ev_ff);
      u_clamped    = clamp_sym(acc, drive_lim_ff);

      // Drop the result once it is taken
      if (rsp_tvalid && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               angle_in    = req_tdata[8:0];
               speed_in    = $signed(req_tdata[24:9]);
               target_in   = req_tdata[56:25];
               offset_in   = req_tdata[88:57];
               hold_in     = req_tuser;
               term_in     = TERM_POS_P;
               mac_ctl     = '{clear: 1'b1, op: cpvp_pkg::MAC_IDLE};
               state_in    = ST_TURN;
            end
         end
         ST_TURN: begin
            unw_ctl  = '{turn_step: 1'b1, advance: 1'b0};
            state_in = ST_POSN;
         end
         ST_POSN: begin
            tprod_in = PW'(turn_count * PW'(TURN_UNITS));
            state_in = ST_ERR;
         end
         ST_ERR: begin
            e_in     = $signed(target_ff - (PW'(pending_angle) + tprod_ff - offset_ff));
            state_in = ST_PSUM;
         end
         ST_PSUM: begin
            // Saturate the position error sum to 32 bits signed
            if (psum_wide[PW] != psum_wide[PW-1]) begin
               pos_sum_in = psum_wide[PW] ? cpvp_pkg::POS_SUM_MIN : cpvp_pkg::POS_SUM_MAX;
            end else begin
               pos_sum_in = PW'(psum_wide);
            end
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            mac_ctl  = '{clear: 1'b0, op: cpvp_pkg::MAC_LOAD};
            state_in = ST_MLO;
         end
         ST_MLO: begin
            mac_ctl  = '{clear: 1'b0, op: cpvp_pkg::MAC_LO};
            state_in = ST_MHI;
         end
         ST_MHI: begin
            mac_ctl  = '{clear: 1'b0, op: cpvp_pkg::MAC_HI};
            state_in = ST_ACC;
         end
         ST_ACC: begin
            mac_ctl = '{clear: 1'b0, op: cpvp_pkg::MAC_ACC};
            if (term_ff == TERM_POS_D) begin
               state_in = ST_UCLP;
            end else if (term_ff == TERM_VEL_D) begin
               state_in = ST_VCLP;
            end else begin
               term_in  = term_ff + 3'd1;
               state_in = ST_LOAD;
            end
         end
         ST_UCLP: begin
            // Clamp the speed target and form the speed error
            ev_in    = cpvp_pkg::EV_W'(u_clamped) - cpvp_pkg::EV_W'(speed_ff);
            mac_ctl  = '{clear: 1'b1, op: cpvp_pkg::MAC_IDLE};
            term_in  = TERM_VEL_P;
            state_in = ST_VSUM;
         end
         ST_VSUM: begin
            spd_sum_in = clamp_sym(AW'(vsum_wide), vint_lim_ff);
            state_in   = ST_LOAD;
         end
         ST_VCLP: begin
            // Wait for a free output register, then commit the tick
            if (out_free) begin
               drive_in     = u_clamped;
               send_in      = !hold_ff;
               out_valid_in = 1'b1;
               last_e_in    = e_ff;
               last_ev_in   = ev_ff;
               unw_ctl      = '{turn_step: 1'b0, advance: 1'b1};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_POS_P;
         out_valid_ff <= 1'b0;
         pos_sum_ff   <= '0;
         last_e_ff    <= '0;
         last_ev_ff   <= '0;
         spd_sum_ff   <= '0;
         pos_gp_ff    <= cpvp_pkg::POS_GAIN_P_RST;
         pos_gi_ff    <= cpvp_pkg::POS_GAIN_I_RST;
         pos_gd_ff    <= cpvp_pkg::POS_GAIN_D_RST;
         vel_gp_ff    <= cpvp_pkg::VEL_GAIN_P_RST;
         vel_gi_ff    <= cpvp_pkg::VEL_GAIN_I_RST;
         vel_gd_ff    <= cpvp_pkg::VEL_GAIN_D_RST;
         drive_lim_ff <= cpvp_pkg::DRIVE_LIMIT_RST;
         vint_lim_ff  <= cpvp_pkg::VEL_INT_LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         out_valid_ff <= out_valid_in;
         pos_sum_ff   <= pos_sum_in;
         last_e_ff    <= last_e_in;
         last_ev_ff   <= last_ev_in;
         spd_sum_ff   <= spd_sum_in;
         pos_gp_ff    <= pos_gp_in;
         pos_gi_ff    <= pos_gi_in;
         pos_gd_ff    <= pos_gd_in;
         vel_gp_ff    <= vel_gp_in;
         vel_gi_ff    <= vel_gi_in;
         vel_gd_ff    <= vel_gd_in;
         drive_lim_ff <= drive_lim_in;
         vint_lim_ff  <= vint_lim_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      angle_ff  <= angle_in;
      speed_ff  <= speed_in;
      target_ff <= target_in;
      offset_ff <= offset_in;
      hold_ff   <= hold_in;
      tprod_ff  <= tprod_in;
      e_ff      <= e_in;
      ev_ff     <= ev_in;
      drive_ff  <= drive_in;
      send_ff   <= send_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = drive_ff;
   assign rsp_tuser  = send_ff;

endmodule

// File: hdl/cpvp_checker.sv
// Port-level checker of the cascaded PID core and its bind to the top level.
`timescale 1ns / 1ps
`include "cascaded_position_velocity_pid_core_macros.svh"

module cpvp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [cpvp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);

   // A stalled item keeps its value
   `CPVP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result item changed while stalled")

   // Accepting an item starts a multi-cycle tick
   `CPVP_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready, "core ready right after taking an item")

   // The clamp never yields the most negative code
   `CPVP_ASSERT(a_drive_symmetric, clock, reset, rsp_tvalid |-> rsp_tdata != 16'h8000, "drive value outside the symmetric range")

   // Reset leaves the core ready and empty
   `CPVP_ASSERT_ALWAYS(a_reset_state, clock, reset |=> !rsp_tvalid && req_tready, "core not idle after reset")

endmodule

bind cascaded_position_velocity_pid_core cpvp_checker u_cpvp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// File: tb/cascaded_position_velocity_pid_core_tb.sv
// Self-checking testbench for the cascaded position and velocity PID core.
`timescale 1ns / 1ps

module cascaded_position_velocity_pid_core_tb;
   import cpvp_pkg::*;

   localparam logic [POS_W-1:0] TURN_STEP = TURN_UNITS_DEF;
   localparam longint           WRAP_STEP = WRAP_THRESHOLD_DEF;
   localparam int               N_REGS    = 8;
   localparam logic [GAIN_W-1:0] FULL_WORD = {GAIN_W{1'b1}};

   // One control tick as offered on the request stream
   typedef struct packed {
      logic [ANGLE_W-1:0]        raw_angle;
      logic signed [SPEED_W-1:0] measured_speed;
      logic signed [POS_W-1:0]   target_position;
      logic signed [POS_W-1:0]   zero_offset;
      logic                      hold_output;
   } tick_item_t;

   // One drive command as returned on the result stream
   typedef struct packed {
      logic [DRIVE_W-1:0] drive_value;
      logic               drive_send;
   } drive_result_t;

   typedef logic [GAIN_W-1:0] loop_regs_t [0:N_REGS-1];

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [GAIN_W-1:0]     csr_wdata;

   // Loop registers and loop state as the predictor sees them
   loop_regs_t         loop_regs;
   logic [ANGLE_W-1:0] pend_angle;
   logic [ANGLE_W-1:0] prev_angle;
   logic [POS_W-1:0]   turn_count;
   longint             last_pos_err;
   longint             pos_err_sum;
   longint             last_speed_err;
   longint             speed_err_sum;

   drive_result_t expected_drives[$];

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int holdoff_request = 0;
   int holdoff_left    = 0;
   int error_count     = 0;
   int ticks_sent      = 0;
   int drives_checked  = 0;
   int settings_used   = 0;

   cascaded_position_velocity_pid_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Q12.12 gain product, truncated toward zero
   function automatic longint scale_q12(input logic [GAIN_W-1:0] gain, input longint val);
      longint unsigned mag;
      mag = (val < 0) ? -val : val;
      mag = (mag * {{(64-GAIN_W){1'b0}}, gain}) >> Q_FRAC;
      return (val < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint clamp_sym(input longint val, input longint lim);
      if (val > lim) return lim;
      if (val < -lim) return -lim;
      return val;
   endfunction

   // Run one control tick on the predictor state and return the drive command
   function automatic drive_result_t predict_drive(input tick_item_t t);
      longint             step;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   diff;
      longint             pos_err;
      longint             speed_cmd;
      longint             speed_err;
      longint             speed_meas;
      longint             drive;
      longint             drive_lim;
      longint             integ_lim;
      drive_result_t      res;
      drive_lim = loop_regs[CSR_DRIVE_LIMIT][LIMIT_W-1:0];
      integ_lim = loop_regs[CSR_VEL_INT_LIMIT][LIMIT_W-1:0];
      speed_meas = t.measured_speed;

      // count a turn when the angle jumps by more than half a turn
      step = longint'(pend_angle) - longint'(prev_angle);
      if (step > WRAP_STEP || step < -WRAP_STEP) begin
         turn_count = (step > 0) ? turn_count - 1 : turn_count + 1;
      end
      position = {{(POS_W-ANGLE_W){1'b0}}, pend_angle} + turn_count * TURN_STEP
                 - t.zero_offset;
      diff = t.target_position - position;
      pos_err = longint'($signed(diff));

      // outer position loop with saturating error sum
      pos_err_sum = pos_err_sum + pos_err;
      if (pos_err_sum > longint'(POS_SUM_MAX)) pos_err_sum = longint'(POS_SUM_MAX);
      if (pos_err_sum < longint'(POS_SUM_MIN)) pos_err_sum = longint'(POS_SUM_MIN);
      speed_cmd = scale_q12(loop_regs[CSR_POS_GAIN_P], pos_err)
                + scale_q12(loop_regs[CSR_POS_GAIN_I], pos_err_sum)
                + scale_q12(loop_regs[CSR_POS_GAIN_D], pos_err - last_pos_err);
      speed_cmd = clamp_sym(speed_cmd, drive_lim);

      // inner velocity loop with clamped error sum
      speed_err = speed_cmd - speed_meas;
      speed_err_sum = clamp_sym(speed_err_sum + speed_err, integ_lim);
      drive = scale_q12(loop_regs[CSR_VEL_GAIN_P], speed_err)
            + scale_q12(loop_regs[CSR_VEL_GAIN_I], speed_err_sum)
            + scale_q12(loop_regs[CSR_VEL_GAIN_D], speed_err - last_speed_err);
      drive = clamp_sym(drive, drive_lim);

      // advance the loop state
      last_pos_err   = pos_err;
      last_speed_err = speed_err;
      prev_angle     = pend_angle;
      pend_angle     = t.raw_angle;

      res.drive_value = drive[DRIVE_W-1:0];
      res.drive_send  = ~t.hold_output;
      return res;
   endfunction

   function automatic tick_item_t make_tick(input int angle, input int speed,
                                            input logic [POS_W-1:0] target,
                                            input logic [POS_W-1:0] offset, input bit hold);
      tick_item_t t;
      t.raw_angle       = angle[ANGLE_W-1:0];
      t.measured_speed  = speed[SPEED_W-1:0];
      t.target_position = target;
      t.zero_offset     = offset;
      t.hold_output     = hold;
      return t;
   endfunction

   function automatic loop_regs_t reset_regs();
      loop_regs_t r;
      r[CSR_POS_GAIN_P]    = POS_GAIN_P_RST;
      r[CSR_POS_GAIN_I]    = POS_GAIN_I_RST;
      r[CSR_POS_GAIN_D]    = POS_GAIN_D_RST;
      r[CSR_VEL_GAIN_P]    = VEL_GAIN_P_RST;
      r[CSR_VEL_GAIN_I]    = VEL_GAIN_I_RST;
      r[CSR_VEL_GAIN_D]    = VEL_GAIN_D_RST;
      r[CSR_DRIVE_LIMIT]   = {{(GAIN_W-LIMIT_W){1'b0}}, DRIVE_LIMIT_RST};
      r[CSR_VEL_INT_LIMIT] = {{(GAIN_W-LIMIT_W){1'b0}}, VEL_INT_LIMIT_RST};
      return r;
   endfunction

   // Moderate gains most of the time, with zero, full-scale and wide picks mixed in
   function automatic loop_regs_t random_regs(input bit wide);
      loop_regs_t r;
      int         pick;
      r[CSR_POS_GAIN_P]    = $urandom_range(0, 1 << 20);
      r[CSR_POS_GAIN_I]    = $urandom_range(0, 256);
      r[CSR_POS_GAIN_D]    = $urandom_range(0, 1 << 18);
      r[CSR_VEL_GAIN_P]    = $urandom_range(0, 1 << 16);
      r[CSR_VEL_GAIN_I]    = $urandom_range(0, 1 << 13);
      r[CSR_VEL_GAIN_D]    = $urandom_range(0, 1 << 14);
      r[CSR_DRIVE_LIMIT]   = $urandom_range(0, 32767);
      r[CSR_VEL_INT_LIMIT] = $urandom_range(0, 32767);
      for (int i = 0; i < N_REGS; i++) begin
         pick = $urandom_range(0, 7);
         if (wide || pick == 0) r[i] = $urandom;
         else if (pick == 1) r[i] = '0;
         else if (pick == 2) r[i] = FULL_WORD;
      end
      return r;
   endfunction

   // Write all loop registers, one per cycle; call only while the core is idle
   task automatic program_loop(input loop_regs_t vals);
      for (int i = 0; i < N_REGS; i++) begin
         csr_wen   <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         loop_regs[i] = vals[i];
      end
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   // Offer one item, optionally after an idle gap, and predict it once taken
   task automatic send_tick(input tick_item_t t);
      int gap;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 40);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-ANGLE_W-SPEED_W-2*POS_W){1'b0}}, t.zero_offset,
                     t.target_position, t.measured_speed, t.raw_angle};
      req_tuser  <= t.hold_output;
      do @(posedge clock); while (req_tready !== 1'b1);
      expected_drives.push_back(predict_drive(t));
      ticks_sent++;
   endtask

   // Stop offering and hold until every predicted drive has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_drives.size() != 0);
   endtask

   task automatic test_directed_extremes();
      send_tick(make_tick(0, 0, 0, 0, 0));
      send_tick(make_tick(359, 32767, 0, 0, 1));
      send_tick(make_tick(0, -32768, 0, 0, 0));
      send_tick(make_tick(350, 100, 360, 0, 0));
      send_tick(make_tick(10, -100, 360, 0, 1));
      send_tick(make_tick(350, 0, 720, 0, 0));
      send_tick(make_tick(511, 0, 32'h7FFF_FFFF, 0, 0));
      send_tick(make_tick(360, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
      send_tick(make_tick(256, 32767, 32'h8000_0000, 32'h8000_0000, 1));
      send_tick(make_tick(180, 5, 32'hFFFF_FFFF, 32'h8000_0000, 0));
      send_tick(make_tick(0, 5, 100, 0, 0));
      send_tick(make_tick(181, -5, 100, 0, 0));
      send_tick(make_tick(0, 0, 100, 0, 0));
      wait_drained();
   endtask

   task automatic test_zero_limits();
      loop_regs_t r;
      r = reset_regs();
      r[CSR_VEL_GAIN_I]    = 24'd8192;
      r[CSR_VEL_GAIN_D]    = 24'd4096;
      r[CSR_DRIVE_LIMIT]   = '0;
      r[CSR_VEL_INT_LIMIT] = '0;
      program_loop(r);
      send_tick(make_tick(90, 1000, 5000, 0, 0));
      send_tick(make_tick(45, -32768, -5000, 0, 1));
      send_tick(make_tick(300, 32767, 32'h7FFF_FFFF, 0, 0));
      wait_drained();
   endtask

   task automatic test_full_scale_gains();
      loop_regs_t r;
      for (int i = 0; i < N_REGS; i++) r[i] = FULL_WORD;
      program_loop(r);
      send_tick(make_tick(200, -32768, 32'h7FFF_FFFF, 32'h8000_0000, 0));
      send_tick(make_tick(20, 32767, 32'h7FFF_FFFF, 32'h8000_0000, 0));
      send_tick(make_tick(220, -32768, 32'h8000_0000, 32'h7FFF_FFFF, 1));
      send_tick(make_tick(40, 32767, 32'h8000_0000, 32'h7FFF_FFFF, 0));
      send_tick(make_tick(1, 0, 0, 0, 0));
      wait_drained();
   endtask

   // Mostly plausible motor motion tracking a nearby target, with noise runs in between
   task automatic run_motion(input int n_items);
      tick_item_t        t;
      int                left;
      int                run_len;
      int                motor_angle;
      int                delta;
      int                pick;
      bit                noisy;
      logic [POS_W-1:0]  offset;
      logic [POS_W-1:0]  here;
      left = n_items;
      while (left > 0) begin
         run_len = $urandom_range(8, 48);
         if (run_len > left) run_len = left;
         noisy = ($urandom_range(0, 99) < 20);
         offset = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000) - 1000;
         motor_angle = (pend_angle < TURN_UNITS_DEF) ? int'(pend_angle) : 0;
         repeat (run_len) begin
            if (noisy) begin
               t.raw_angle       = $urandom_range(0, 511);
               t.measured_speed  = SPEED_W'($urandom);
               t.target_position = $urandom;
               t.zero_offset     = $urandom;
               t.hold_output     = $urandom_range(0, 1);
            end else begin
               pick = $urandom_range(0, 19);
               if (pick == 0) begin
                  delta = $urandom_range(170, 190);
                  if ($urandom_range(0, 1)) delta = -delta;
               end else begin
                  delta = int'($urandom_range(0, 80)) - 40;
               end
               motor_angle = (motor_angle + delta + TURN_UNITS_DEF) % TURN_UNITS_DEF;
               t.raw_angle = (pick == 1) ? $urandom_range(TURN_UNITS_DEF, 511) : motor_angle;
               here = {{(POS_W-ANGLE_W){1'b0}}, pend_angle} + turn_count * TURN_STEP - offset;
               delta = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 20000)) - 10000
                                                   : int'($urandom_range(0, 600)) - 300;
               t.target_position = here + delta;
               t.measured_speed  = ($urandom_range(0, 7) == 0) ? SPEED_W'($urandom)
                                   : SPEED_W'(int'($urandom_range(0, 3000)) - 1500);
               t.zero_offset     = offset;
               t.hold_output     = ($urandom_range(0, 4) == 0);
            end
            send_tick(t);
            left--;
         end
      end
   endtask

   // Random phases, each under its own register setting, cycling through four idle patterns
   task automatic test_random_phases();
      for (int seg = 0; seg < 8; seg++) begin
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         program_loop((seg == 0) ? reset_regs() : random_regs(seg % 3 == 2));
         run_motion(240);
         wait_drained();
      end
   endtask

   // Hold the result side off for a long stretch while items keep coming
   task automatic test_result_backpressure();
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      holdoff_request = 400;
      run_motion(24);
      wait_drained();
   endtask

   // Result side ready pattern, with long hold-offs counted here
   always @(posedge clock) begin
      if (holdoff_request != 0) begin
         holdoff_left = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_drives
      drive_result_t want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_drives.size() == 0) begin
            $error("drive result with none expected: drive_value %0d, drive_send %0b",
                   $signed(rsp_tdata), rsp_tuser);
            error_count++;
         end else begin
            want = expected_drives.pop_front();
            drives_checked++;
            if (rsp_tdata !== want.drive_value) begin
               $error("drive_value: expected %0d, actual %0d",
                      $signed(want.drive_value), $signed(rsp_tdata));
               error_count++;
            end
            if (rsp_tuser !== want.drive_send) begin
               $error("drive_send: expected %0b, actual %0b", want.drive_send, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   initial begin
      #12_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tvalid = 1'b0;
      rsp_tready = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      loop_regs  = reset_regs();
      pend_angle = '0;
      prev_angle = '0;
      turn_count = '0;
      last_pos_err   = 0;
      pos_err_sum    = 0;
      last_speed_err = 0;
      speed_err_sum  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_zero_limits();
      test_full_scale_gains();
      test_random_phases();
      test_result_backpressure();

      // let any stray result show up before closing
      repeat (64) @(posedge clock);
      if (expected_drives.size() != 0) begin
         $error("%0d drive results never arrived", expected_drives.size());
         error_count++;
      end
      $display("Ran %0d control ticks under %0d register settings and four idle patterns.",
               ticks_sent, settings_used);
      $display("Compared %0d drive results, including turn wraps, holds and zero limits.",
               drives_checked);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
